@@ hdl/ssae_pkg.sv @@
// Shared constants, codes and types of the sprite slot animation engine.
// No dependencies; ssae_tick and the top level refer to it by scoped names.
package ssae_pkg;

  localparam int SLOTS = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [2:0] CMD_START_STATIC = 3'd0;
  localparam logic [2:0] CMD_START_MOVING = 3'd1;
  localparam logic [2:0] CMD_SET_POS      = 3'd2;
  localparam logic [2:0] CMD_QUERY        = 3'd3;
  localparam logic [2:0] CMD_STOP         = 3'd4;
  localparam logic [2:0] CMD_TICK         = 3'd5;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DRAW  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;
  localparam logic [1:0] KIND_ACK   = 2'd3;

  localparam logic [14:0] MOVING_REPEATS = 15'd10000;
  localparam logic [15:0] KEEP_COORD     = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK_RUN,
    ST_TICK_DONE
  } state_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  step_x;
    logic [7:0]  step_y;
    logic [15:0] end_x;
    logic [15:0] end_y;
    logic [7:0]  frame;
    logic [7:0]  frame_total;
    logic [14:0] period;
    logic [14:0] phase;
    logic [14:0] repeats;
  } slot_rec_t;

endpackage

@@ hdl/ssae_cmd_if.sv @@
// Command channel of the sprite slot animation engine: valid, ready and
// the fields of one command. No dependencies.
interface ssae_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [3:0]         slot;
  logic signed [15:0] x;
  logic signed [15:0] y;
  logic signed [7:0]  x_step;
  logic signed [7:0]  y_step;
  logic signed [15:0] end_x;
  logic signed [15:0] end_y;
  logic [14:0]        repeat_count;
  logic [7:0]         frame_count;
  logic [14:0]        frame_period;

  modport source (
    output valid, command, slot, x, y, x_step, y_step, end_x, end_y,
           repeat_count, frame_count, frame_period,
    input  ready
  );
  modport sink (
    input  valid, command, slot, x, y, x_step, y_step, end_x, end_y,
           repeat_count, frame_count, frame_period,
    output ready
  );
endinterface

@@ hdl/ssae_rsp_if.sv @@
// Reply channel of the sprite slot animation engine: valid, ready and
// the fields of one reply. No dependencies.
interface ssae_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         reply_kind;
  logic [3:0]         reply_slot;
  logic               success;
  logic [7:0]         frame;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic               last;

  modport source (
    output valid, reply_kind, reply_slot, success, frame, out_x, out_y, last,
    input  ready
  );
  modport sink (
    input  valid, reply_kind, reply_slot, success, frame, out_x, out_y, last,
    output ready
  );
endinterface

@@ hdl/ssae_tick.sv @@
// Per-slot tick update: moves a moving slot, checks its end point and advances
// its animation frame. Depends on ssae_pkg.
module ssae_tick (
  input  ssae_pkg::slot_rec_t rec,
  input  logic                moving,
  output ssae_pkg::slot_rec_t rec_next,
  output logic                keep
);

  logic [15:0] nx;
  logic [15:0] ny;
  logic        stop;
  logic [14:0] period_eff;
  logic [15:0] ph;
  logic [8:0]  frame_inc;

  assign nx = rec.x + {{8{rec.step_x[7]}}, rec.step_x};
  assign ny = rec.y + {{8{rec.step_y[7]}}, rec.step_y};

  assign stop = (rec.step_x == 8'd0 && rec.step_y == 8'd0)
    || (!rec.step_x[7] && rec.step_x != 8'd0 && $signed(nx) > $signed(rec.end_x))
    || (rec.step_x[7] && $signed(nx) < $signed(rec.end_x))
    || (!rec.step_y[7] && rec.step_y != 8'd0 && $signed(ny) > $signed(rec.end_y))
    || (rec.step_y[7] && $signed(ny) < $signed(rec.end_y));

  assign period_eff = (rec.period == 15'd0) ? 15'd1 : rec.period;
  assign ph = {1'b0, rec.phase} + 16'd1;
  assign frame_inc = {1'b0, rec.frame} + 9'd1;

  always_comb begin
    rec_next = rec;
    keep = 1'b1;
    if (moving) begin
      rec_next.x = nx;
      rec_next.y = ny;
    end
    if (moving && stop) begin
      keep = 1'b0;
    end else if (ph < {1'b0, period_eff}) begin
      rec_next.phase = ph[14:0];
    end else begin
      rec_next.phase = 15'd0;
      if (frame_inc < {1'b0, rec.frame_total}) begin
        rec_next.frame = frame_inc[7:0];
      end else if (rec.repeats <= 15'd1) begin
        keep = 1'b0;
      end else begin
        rec_next.frame = 8'd0;
        rec_next.repeats = rec.repeats - 15'd1;
      end
    end
  end

endmodule

@@ hdl/sprite_slot_animation_engine_unit.sv @@
// Top level of the sprite slot animation engine: slot table memory,
// command sequencer and reply register. Depends on ssae_pkg, ssae_cmd_if,
// ssae_rsp_if and ssae_tick.
//
//   Port  Dir  Carries
//   cmd   in   one command per transaction (start, set, query, stop, tick)
//   rsp   out  replies; a tick gives one draw per active slot, then a done
//
// Other commands: accept in ST_IDLE, then execute and reply in ST_EXEC.
// A tick reads one slot record per cycle from the slot memory, stalling on
// reply back-pressure; each is updated and written back as the next is read.
// Reply back-pressure holds the sequencer in place. Reset clears the active
// and moving bits at once; the slot memory needs no clearing.
module sprite_slot_animation_engine_unit (
  input  logic           clk,
  input  logic           rst,
  ssae_cmd_if.sink       cmd,
  ssae_rsp_if.source     rsp
);

  localparam logic [ssae_pkg::SLOT_W-1:0] LAST_SLOT =
    ssae_pkg::SLOT_W'(ssae_pkg::SLOTS - 1);

  ssae_pkg::slot_rec_t mem [ssae_pkg::SLOTS];
  ssae_pkg::slot_rec_t rdata;
  ssae_pkg::slot_rec_t tick_rec;
  ssae_pkg::slot_rec_t start_rec;
  ssae_pkg::slot_rec_t set_rec;
  ssae_pkg::slot_rec_t mem_wdata;

  ssae_pkg::state_t state;
  ssae_pkg::state_t state_next;

  logic [ssae_pkg::SLOTS-1:0] slot_active;
  logic [ssae_pkg::SLOTS-1:0] slot_moving;
  logic [ssae_pkg::SLOT_W-1:0] cur;

  logic [2:0]  command_q;
  logic [3:0]  slot_q;
  logic [15:0] x_q;
  logic [15:0] y_q;
  logic [7:0]  x_step_q;
  logic [7:0]  y_step_q;
  logic [15:0] end_x_q;
  logic [15:0] end_y_q;
  logic [14:0] repeat_count_q;
  logic [7:0]  frame_count_q;
  logic [14:0] frame_period_q;

  logic        out_valid;
  logic [1:0]  out_kind;
  logic [3:0]  out_slot;
  logic        out_ok;
  logic [7:0]  out_frame;
  logic [15:0] out_xr;
  logic [15:0] out_yr;
  logic        out_last;

  logic        out_free;
  logic        emit;
  logic [1:0]  e_kind;
  logic [3:0]  e_slot;
  logic        e_ok;
  logic [7:0]  e_frame;
  logic [15:0] e_x;
  logic [15:0] e_y;
  logic        e_last;

  logic                        mem_re;
  logic [ssae_pkg::SLOT_W-1:0] mem_raddr;
  logic                        mem_we;
  logic [ssae_pkg::SLOT_W-1:0] mem_waddr;
  logic                        act_set;
  logic                        act_clr;
  logic [ssae_pkg::SLOT_W-1:0] act_idx;
  logic                        mov_val;
  logic                        cur_adv;
  logic                        in_ready;

  logic [ssae_pkg::SLOT_W-1:0] slot_idx_in;
  logic [ssae_pkg::SLOT_W-1:0] slot_idx_q;
  logic                        ok_q;
  logic                        tick_keep;
  logic                        tick_stall;
  logic                        found;
  logic [ssae_pkg::SLOT_W-1:0] free_idx;
  logic                        is_moving;

  assign slot_idx_in = ssae_pkg::SLOT_W'(cmd.slot);
  assign slot_idx_q  = ssae_pkg::SLOT_W'(slot_q);
  assign ok_q = (int'(slot_q) < ssae_pkg::SLOTS) && slot_active[slot_idx_q];
  assign out_free = !out_valid || rsp.ready;
  assign tick_stall = slot_active[cur] && !out_free;
  assign is_moving = (command_q == ssae_pkg::CMD_START_MOVING);

  ssae_tick u_tick (
    .rec      (rdata),
    .moving   (slot_moving[cur]),
    .rec_next (tick_rec),
    .keep     (tick_keep)
  );

  always_comb begin
    found = 1'b0;
    free_idx = '0;
    for (int i = ssae_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!slot_active[i]) begin
        found = 1'b1;
        free_idx = ssae_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    start_rec.x = x_q;
    start_rec.y = y_q;
    start_rec.step_x = is_moving ? x_step_q : 8'd0;
    start_rec.step_y = is_moving ? y_step_q : 8'd0;
    start_rec.end_x = is_moving ? end_x_q : 16'd0;
    start_rec.end_y = is_moving ? end_y_q : 16'd0;
    start_rec.frame = 8'd0;
    start_rec.frame_total = frame_count_q;
    start_rec.period = frame_period_q;
    start_rec.phase = 15'd0;
    start_rec.repeats = is_moving ? ssae_pkg::MOVING_REPEATS : repeat_count_q;
  end

  always_comb begin
    set_rec = rdata;
    if (x_q != ssae_pkg::KEEP_COORD) begin
      set_rec.x = x_q;
    end
    if (y_q != ssae_pkg::KEEP_COORD) begin
      set_rec.y = y_q;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ssae_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          state_next = (cmd.command == ssae_pkg::CMD_TICK) ?
                       ssae_pkg::ST_TICK_RUN : ssae_pkg::ST_EXEC;
        end
      end
      ssae_pkg::ST_EXEC: begin
        if (out_free) begin
          state_next = ssae_pkg::ST_IDLE;
        end
      end
      ssae_pkg::ST_TICK_RUN: begin
        if (!tick_stall && cur == LAST_SLOT) begin
          state_next = ssae_pkg::ST_TICK_DONE;
        end
      end
      ssae_pkg::ST_TICK_DONE: begin
        if (out_free) begin
          state_next = ssae_pkg::ST_IDLE;
        end
      end
      default: state_next = ssae_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    emit = 1'b0;
    e_kind = ssae_pkg::KIND_ACK;
    e_slot = slot_q;
    e_ok = 1'b0;
    e_frame = 8'd0;
    e_x = 16'd0;
    e_y = 16'd0;
    e_last = 1'b1;
    mem_re = 1'b0;
    mem_raddr = slot_idx_in;
    mem_we = 1'b0;
    mem_waddr = slot_idx_q;
    mem_wdata = set_rec;
    act_set = 1'b0;
    act_clr = 1'b0;
    act_idx = slot_idx_q;
    mov_val = 1'b0;
    cur_adv = 1'b0;
    case (state)
      ssae_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (cmd.valid) begin
          mem_re = 1'b1;
          if (cmd.command == ssae_pkg::CMD_TICK) begin
            mem_raddr = '0;
          end
        end
      end
      ssae_pkg::ST_EXEC: begin
        if (out_free) begin
          emit = 1'b1;
          case (command_q)
            ssae_pkg::CMD_START_STATIC, ssae_pkg::CMD_START_MOVING: begin
              e_kind = ssae_pkg::KIND_START;
              e_slot = 4'd0;
              if (found) begin
                e_slot = 4'(free_idx);
                e_ok = 1'b1;
                mem_we = 1'b1;
                mem_waddr = free_idx;
                mem_wdata = start_rec;
                act_set = 1'b1;
                act_idx = free_idx;
                mov_val = is_moving;
              end
            end
            ssae_pkg::CMD_SET_POS: begin
              e_ok = ok_q;
              mem_we = ok_q;
            end
            ssae_pkg::CMD_QUERY: begin
              e_kind = ssae_pkg::KIND_QUERY;
              e_ok = ok_q;
              if (ok_q) begin
                e_x = rdata.x;
                e_y = rdata.y;
              end
            end
            ssae_pkg::CMD_STOP: begin
              e_ok = ok_q;
              act_clr = ok_q;
            end
            default: e_ok = 1'b0;
          endcase
        end
      end
      ssae_pkg::ST_TICK_RUN: begin
        if (!tick_stall) begin
          if (slot_active[cur]) begin
            emit = 1'b1;
            e_kind = ssae_pkg::KIND_DRAW;
            e_slot = 4'(cur);
            e_ok = 1'b1;
            e_frame = rdata.frame;
            e_x = rdata.x;
            e_y = rdata.y;
            e_last = 1'b0;
            mem_we = 1'b1;
            mem_waddr = cur;
            mem_wdata = tick_rec;
            act_clr = !tick_keep;
            act_idx = cur;
          end
          if (cur != LAST_SLOT) begin
            cur_adv = 1'b1;
            mem_re = 1'b1;
            mem_raddr = cur + 1'b1;
          end
        end
      end
      ssae_pkg::ST_TICK_DONE: begin
        if (out_free) begin
          emit = 1'b1;
          e_slot = 4'd0;
          e_ok = 1'b1;
        end
      end
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssae_pkg::ST_IDLE;
      slot_active <= '0;
      slot_moving <= '0;
      cur <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (act_set) begin
        slot_active[act_idx] <= 1'b1;
        slot_moving[act_idx] <= mov_val;
      end else if (act_clr) begin
        slot_active[act_idx] <= 1'b0;
      end
      if (state == ssae_pkg::ST_IDLE) begin
        cur <= '0;
      end else if (cur_adv) begin
        cur <= cur + 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && cmd.valid) begin
      command_q <= cmd.command;
      slot_q <= cmd.slot;
      x_q <= cmd.x;
      y_q <= cmd.y;
      x_step_q <= cmd.x_step;
      y_step_q <= cmd.y_step;
      end_x_q <= cmd.end_x;
      end_y_q <= cmd.end_y;
      repeat_count_q <= cmd.repeat_count;
      frame_count_q <= cmd.frame_count;
      frame_period_q <= cmd.frame_period;
    end
    if (emit) begin
      out_kind <= e_kind;
      out_slot <= e_slot;
      out_ok <= e_ok;
      out_frame <= e_frame;
      out_xr <= e_x;
      out_yr <= e_y;
      out_last <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  assign cmd.ready = in_ready;
  assign rsp.valid = out_valid;
  assign rsp.reply_kind = out_kind;
  assign rsp.reply_slot = out_slot;
  assign rsp.success = out_ok;
  assign rsp.frame = out_frame;
  assign rsp.out_x = out_xr;
  assign rsp.out_y = out_yr;
  assign rsp.last = out_last;

endmodule

@@ test/sprite_slot_animation_engine_unit_tb.sv @@
// Testbench for sprite_slot_animation_engine_unit: drives sprite commands,
// predicts every reply from a slot table of its own and checks each reply.
// Depends on ssae_pkg, ssae_cmd_if, ssae_rsp_if and the engine's RTL.
module sprite_slot_animation_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_UNUSED_A = 3'd6;
  localparam logic [2:0] CMD_UNUSED_B = 3'd7;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE_CYCLES = 4 * (ssae_pkg::SLOTS + 2);

  typedef struct packed {
    logic [2:0]         op;
    logic [3:0]         slot;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [7:0]  dx;
    logic signed [7:0]  dy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic [14:0]        reps;
    logic [7:0]         frames;
    logic [14:0]        per;
  } sprite_cmd_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         slot;
    logic               ok;
    logic [7:0]         frame;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
  } sprite_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ssae_cmd_if cmd_bus ();
  ssae_rsp_if rsp_bus ();

  sprite_slot_animation_engine_unit dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .rsp (rsp_bus)
  );

  logic               slot_on   [ssae_pkg::SLOTS];
  logic               slot_mv   [ssae_pkg::SLOTS];
  logic signed [15:0] pos_x     [ssae_pkg::SLOTS];
  logic signed [15:0] pos_y     [ssae_pkg::SLOTS];
  logic signed [7:0]  stp_x     [ssae_pkg::SLOTS];
  logic signed [7:0]  stp_y     [ssae_pkg::SLOTS];
  logic signed [15:0] lim_x     [ssae_pkg::SLOTS];
  logic signed [15:0] lim_y     [ssae_pkg::SLOTS];
  logic [7:0]         frm       [ssae_pkg::SLOTS];
  logic [7:0]         frm_total [ssae_pkg::SLOTS];
  logic [14:0]        per       [ssae_pkg::SLOTS];
  logic [14:0]        phs       [ssae_pkg::SLOTS];
  logic [14:0]        reps      [ssae_pkg::SLOTS];

  sprite_reply_t expected_replies[$];
  int mismatches = 0;
  bit no_idle = 1'b0;
  int stall_left = 0;

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_reply(logic [1:0] kind, logic [3:0] slot, logic ok,
                                     logic [7:0] frame, logic signed [15:0] x,
                                     logic signed [15:0] y, logic last);
    sprite_reply_t r;
    r.kind = kind;
    r.slot = slot;
    r.ok = ok;
    r.frame = frame;
    r.x = x;
    r.y = y;
    r.last = last;
    expected_replies.push_back(r);
  endfunction

  function automatic void advance_slot(int i);
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    int period;
    int next_phase;
    bit halt;
    if (slot_mv[i]) begin
      nx = pos_x[i] + stp_x[i];
      ny = pos_y[i] + stp_y[i];
      pos_x[i] = nx;
      pos_y[i] = ny;
      halt = (stp_x[i] == 0 && stp_y[i] == 0)
          || (stp_x[i] > 0 && nx > lim_x[i]) || (stp_x[i] < 0 && nx < lim_x[i])
          || (stp_y[i] > 0 && ny > lim_y[i]) || (stp_y[i] < 0 && ny < lim_y[i]);
      if (halt) begin
        slot_on[i] = 1'b0;
        return;
      end
    end
    period = (per[i] == 0) ? 1 : int'(per[i]);
    next_phase = int'(phs[i]) + 1;
    if (next_phase < period) begin
      phs[i] = 15'(next_phase);
      return;
    end
    phs[i] = '0;
    if (int'(frm[i]) + 1 < int'(frm_total[i])) begin
      frm[i] = frm[i] + 8'd1;
    end else if (reps[i] <= 1) begin
      slot_on[i] = 1'b0;
    end else begin
      frm[i] = '0;
      reps[i] = reps[i] - 15'd1;
    end
  endfunction

  function automatic void predict_replies(sprite_cmd_t c);
    int n;
    bit moving;
    logic live;
    live = slot_on[c.slot];
    case (c.op)
      ssae_pkg::CMD_START_STATIC, ssae_pkg::CMD_START_MOVING: begin
        moving = (c.op == ssae_pkg::CMD_START_MOVING);
        n = -1;
        for (int i = 0; i < ssae_pkg::SLOTS; i++) begin
          if (n < 0 && !slot_on[i]) n = i;
        end
        if (n < 0) begin
          push_reply(ssae_pkg::KIND_START, '0, 1'b0, '0, '0, '0, 1'b1);
        end else begin
          slot_on[n] = 1'b1;
          slot_mv[n] = moving;
          pos_x[n] = c.x;
          pos_y[n] = c.y;
          stp_x[n] = moving ? c.dx : '0;
          stp_y[n] = moving ? c.dy : '0;
          lim_x[n] = moving ? c.ex : '0;
          lim_y[n] = moving ? c.ey : '0;
          reps[n] = moving ? ssae_pkg::MOVING_REPEATS : c.reps;
          frm_total[n] = c.frames;
          per[n] = c.per;
          frm[n] = '0;
          phs[n] = '0;
          push_reply(ssae_pkg::KIND_START, 4'(n), 1'b1, '0, '0, '0, 1'b1);
        end
      end
      ssae_pkg::CMD_SET_POS: begin
        if (live) begin
          if (c.x != ssae_pkg::KEEP_COORD) pos_x[c.slot] = c.x;
          if (c.y != ssae_pkg::KEEP_COORD) pos_y[c.slot] = c.y;
        end
        push_reply(ssae_pkg::KIND_ACK, c.slot, live, '0, '0, '0, 1'b1);
      end
      ssae_pkg::CMD_QUERY: begin
        if (live) begin
          push_reply(ssae_pkg::KIND_QUERY, c.slot, 1'b1, '0, pos_x[c.slot],
                     pos_y[c.slot], 1'b1);
        end else begin
          push_reply(ssae_pkg::KIND_QUERY, c.slot, 1'b0, '0, '0, '0, 1'b1);
        end
      end
      ssae_pkg::CMD_STOP: begin
        if (live) slot_on[c.slot] = 1'b0;
        push_reply(ssae_pkg::KIND_ACK, c.slot, live, '0, '0, '0, 1'b1);
      end
      ssae_pkg::CMD_TICK: begin
        for (int i = 0; i < ssae_pkg::SLOTS; i++) begin
          if (slot_on[i]) begin
            push_reply(ssae_pkg::KIND_DRAW, 4'(i), 1'b1, frm[i], pos_x[i], pos_y[i],
                       1'b0);
            advance_slot(i);
          end
        end
        push_reply(ssae_pkg::KIND_ACK, '0, 1'b1, '0, '0, '0, 1'b1);
      end
      default: begin
        push_reply(ssae_pkg::KIND_ACK, c.slot, 1'b0, '0, '0, '0, 1'b1);
      end
    endcase
  endfunction

  function automatic int live_slots();
    int n;
    n = 0;
    for (int i = 0; i < ssae_pkg::SLOTS; i++) begin
      if (slot_on[i]) n++;
    end
    return n;
  endfunction

  function automatic logic [3:0] pick_live_slot();
    int live[$];
    for (int i = 0; i < ssae_pkg::SLOTS; i++) begin
      if (slot_on[i]) live.push_back(i);
    end
    if (live.size() == 0) return 4'($urandom);
    return 4'(live[$urandom_range(0, live.size() - 1)]);
  endfunction

  function automatic sprite_cmd_t random_fields();
    sprite_cmd_t c;
    c.op = 3'($urandom_range(0, 5));
    c.slot = 4'($urandom);
    c.x = 16'($urandom);
    c.y = 16'($urandom);
    c.dx = 8'($urandom);
    c.dy = 8'($urandom);
    c.ex = 16'($urandom);
    c.ey = 16'($urandom);
    c.reps = 15'($urandom);
    c.frames = 8'($urandom_range(1, 255));
    c.per = 15'($urandom_range(1, 32767));
    return c;
  endfunction

  function automatic sprite_cmd_t slot_cmd(logic [2:0] op, logic [3:0] slot,
                                           logic signed [15:0] x, logic signed [15:0] y);
    sprite_cmd_t c;
    c = random_fields();
    c.op = op;
    c.slot = slot;
    c.x = x;
    c.y = y;
    return c;
  endfunction

  function automatic sprite_cmd_t start_cmd(logic [2:0] op, logic signed [15:0] x,
                                            logic signed [15:0] y, logic signed [7:0] dx,
                                            logic signed [7:0] dy, logic signed [15:0] ex,
                                            logic signed [15:0] ey, logic [14:0] r,
                                            logic [7:0] frames, logic [14:0] p);
    sprite_cmd_t c;
    c = slot_cmd(op, 4'($urandom), x, y);
    c.dx = dx;
    c.dy = dy;
    c.ex = ex;
    c.ey = ey;
    c.reps = r;
    c.frames = frames;
    c.per = p;
    return c;
  endfunction

  function automatic sprite_cmd_t random_sprite_cmd();
    sprite_cmd_t c;
    int w;
    c = random_fields();
    w = $urandom_range(0, 99);
    if (w < 18) c.op = ssae_pkg::CMD_START_STATIC;
    else if (w < 36) c.op = ssae_pkg::CMD_START_MOVING;
    else if (w < 48) c.op = ssae_pkg::CMD_SET_POS;
    else if (w < 58) c.op = ssae_pkg::CMD_QUERY;
    else if (w < 70) c.op = ssae_pkg::CMD_STOP;
    else c.op = ssae_pkg::CMD_TICK;
    // Most sprites are short-lived so that frames wrap, repeats run out
    // and moving sprites reach their end points within a few ticks.
    if ($urandom_range(0, 99) < 85) begin
      c.reps = 15'($urandom_range(0, 3));
      c.frames = 8'($urandom_range(1, 4));
      c.per = 15'($urandom_range(1, 3));
      c.dx = 8'($urandom_range(0, 8) - 4);
      c.dy = 8'($urandom_range(0, 8) - 4);
      c.ex = c.x + 16'(int'(c.dx) * $urandom_range(0, 6));
      c.ey = c.y + 16'(int'(c.dy) * $urandom_range(0, 6));
    end
    if ((c.op == ssae_pkg::CMD_SET_POS || c.op == ssae_pkg::CMD_QUERY
         || c.op == ssae_pkg::CMD_STOP) && $urandom_range(0, 99) < 80) begin
      c.slot = pick_live_slot();
    end
    if (c.op == ssae_pkg::CMD_SET_POS) begin
      if ($urandom_range(0, 3) == 0) c.x = -16'sd1;
      if ($urandom_range(0, 3) == 0) c.y = -16'sd1;
    end
    return c;
  endfunction

  task automatic send_cmd(sprite_cmd_t c);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.command <= c.op;
    cmd_bus.slot <= c.slot;
    cmd_bus.x <= c.x;
    cmd_bus.y <= c.y;
    cmd_bus.x_step <= c.dx;
    cmd_bus.y_step <= c.dy;
    cmd_bus.end_x <= c.ex;
    cmd_bus.end_y <= c.ey;
    cmd_bus.repeat_count <= c.reps;
    cmd_bus.frame_count <= c.frames;
    cmd_bus.frame_period <= c.per;
    do @(posedge clk); while (cmd_bus.ready !== 1'b1);
    predict_replies(c);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    cmd_bus.valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void note_failure(string what, sprite_reply_t exp, sprite_reply_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s: expected kind %0d slot %0d ok %0b frame %0d x %0d y %0d last %0b",
               $time, what, exp.kind, exp.slot, exp.ok, exp.frame, exp.x, exp.y, exp.last);
      $display("%0t: %s: actual   kind %0d slot %0d ok %0b frame %0d x %0d y %0d last %0b",
               $time, what, got.kind, got.slot, got.ok, got.frame, got.x, got.y, got.last);
    end
  endfunction

  task automatic check_reply();
    sprite_reply_t got;
    sprite_reply_t exp;
    got.kind = rsp_bus.reply_kind;
    got.slot = rsp_bus.reply_slot;
    got.ok = rsp_bus.success;
    got.frame = rsp_bus.frame;
    got.x = rsp_bus.out_x;
    got.y = rsp_bus.out_y;
    got.last = rsp_bus.last;
    if (expected_replies.size() == 0) begin
      note_failure("unexpected reply", '0, got);
    end else begin
      exp = expected_replies.pop_front();
      if (got.kind !== exp.kind || got.slot !== exp.slot || got.ok !== exp.ok
          || got.frame !== exp.frame || got.x !== exp.x || got.y !== exp.y
          || got.last !== exp.last) begin
        note_failure("reply mismatch", exp, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) check_reply();
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      rsp_bus.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      rsp_bus.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  task automatic test_directed();
    send_cmd(slot_cmd(ssae_pkg::CMD_QUERY, 4'd5, 16'sd0, 16'sd0));
    send_cmd(slot_cmd(ssae_pkg::CMD_SET_POS, 4'd15, 16'sd100, 16'sd100));
    send_cmd(slot_cmd(ssae_pkg::CMD_STOP, 4'd0, 16'sd0, 16'sd0));
    send_cmd(slot_cmd(CMD_UNUSED_A, 4'd9, 16'sd0, 16'sd0));
    send_cmd(slot_cmd(CMD_UNUSED_B, 4'd15, 16'sd0, 16'sd0));
    send_cmd(start_cmd(ssae_pkg::CMD_START_STATIC, 16'sd32767, -16'sd32768, 8'sd0, 8'sd0,
                       16'sd0, 16'sd0, 15'd32767, 8'd255, 15'd32767));
    // Zero frame count and zero period both act as one.
    send_cmd(start_cmd(ssae_pkg::CMD_START_STATIC, -16'sd1, 16'sd0, 8'sd0, 8'sd0,
                       16'sd0, 16'sd0, 15'd0, 8'd0, 15'd0));
    // Steps wrap both coordinates around the 16-bit range.
    send_cmd(start_cmd(ssae_pkg::CMD_START_MOVING, -16'sd32768, 16'sd32767, -8'sd128,
                       8'sd127, -16'sd32768, 16'sd32767, 15'd32767, 8'd1, 15'd1));
    send_cmd(start_cmd(ssae_pkg::CMD_START_MOVING, 16'sd0, 16'sd0, 8'sd0, 8'sd0,
                       16'sd0, 16'sd0, 15'd0, 8'd2, 15'd1));
    send_cmd(start_cmd(ssae_pkg::CMD_START_MOVING, 16'sd0, 16'sd0, 8'sd1, 8'sd0,
                       16'sd0, 16'sd0, 15'd0, 8'd2, 15'd1));
    send_cmd(start_cmd(ssae_pkg::CMD_START_MOVING, 16'sd100, -16'sd100, -8'sd5, 8'sd5,
                       16'sd80, -16'sd80, 15'd1, 8'd3, 15'd2));
    send_cmd(slot_cmd(ssae_pkg::CMD_SET_POS, 4'd0, -16'sd1, 16'sd100));
    send_cmd(slot_cmd(ssae_pkg::CMD_SET_POS, 4'd0, 16'sd5, -16'sd1));
    send_cmd(slot_cmd(ssae_pkg::CMD_SET_POS, 4'd2, -16'sd1, -16'sd1));
    send_cmd(slot_cmd(ssae_pkg::CMD_QUERY, 4'd0, 16'sd0, 16'sd0));
    send_cmd(slot_cmd(ssae_pkg::CMD_QUERY, 4'd2, 16'sd0, 16'sd0));
    repeat (4) begin
      send_cmd(slot_cmd(ssae_pkg::CMD_TICK, 4'($urandom), 16'($urandom), 16'($urandom)));
    end
    send_cmd(slot_cmd(ssae_pkg::CMD_STOP, 4'd2, 16'sd0, 16'sd0));
    send_cmd(slot_cmd(ssae_pkg::CMD_STOP, 4'd2, 16'sd0, 16'sd0));
    send_cmd(slot_cmd(ssae_pkg::CMD_QUERY, 4'd2, 16'sd0, 16'sd0));
    send_cmd(slot_cmd(ssae_pkg::CMD_TICK, 4'd15, 16'sd0, 16'sd0));
    wait_idle();
  endtask

  task automatic test_full_table();
    sprite_cmd_t c;
    while (live_slots() < ssae_pkg::SLOTS) begin
      if ($urandom_range(0, 1) == 1) begin
        c = start_cmd(ssae_pkg::CMD_START_MOVING, 16'($urandom_range(0, 2000) - 1000),
                      16'($urandom), 8'($urandom_range(1, 4)), 8'sd0, 16'sd30000,
                      16'($urandom), 15'($urandom), 8'd3, 15'd2);
      end else begin
        c = start_cmd(ssae_pkg::CMD_START_STATIC, 16'($urandom), 16'($urandom),
                      8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), 15'd50,
                      8'd3, 15'd2);
      end
      send_cmd(c);
    end
    send_cmd(start_cmd(ssae_pkg::CMD_START_STATIC, 16'sd1, 16'sd1, 8'sd0, 8'sd0, 16'sd0,
                       16'sd0, 15'd5, 8'd1, 15'd1));
    send_cmd(start_cmd(ssae_pkg::CMD_START_MOVING, 16'sd1, 16'sd1, 8'sd1, 8'sd1, 16'sd9,
                       16'sd9, 15'd5, 8'd1, 15'd1));
    repeat (2) begin
      send_cmd(slot_cmd(ssae_pkg::CMD_TICK, 4'($urandom), 16'($urandom), 16'($urandom)));
    end
    repeat (8) begin
      send_cmd(slot_cmd(ssae_pkg::CMD_STOP, pick_live_slot(), 16'($urandom),
                        16'($urandom)));
    end
    wait_idle();
  endtask

  task automatic test_random_traffic(int count);
    repeat (count) send_cmd(random_sprite_cmd());
    wait_idle();
  endtask

  task automatic test_back_to_back(int count);
    no_idle = 1'b1;
    repeat (count) send_cmd(random_sprite_cmd());
    wait_idle();
    no_idle = 1'b0;
  endtask

  initial begin
    cmd_bus.valid = 1'b0;
    cmd_bus.command = '0;
    cmd_bus.slot = '0;
    cmd_bus.x = '0;
    cmd_bus.y = '0;
    cmd_bus.x_step = '0;
    cmd_bus.y_step = '0;
    cmd_bus.end_x = '0;
    cmd_bus.end_y = '0;
    cmd_bus.repeat_count = '0;
    cmd_bus.frame_count = '0;
    cmd_bus.frame_period = '0;
    rsp_bus.ready = 1'b0;
    for (int i = 0; i < ssae_pkg::SLOTS; i++) begin
      slot_on[i] = 1'b0;
      slot_mv[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_table();
    test_random_traffic(110);
    test_back_to_back(30);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("sprite_slot_animation_engine_unit_tb passed");
    end else begin
      $display("sprite_slot_animation_engine_unit_tb failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("sprite_slot_animation_engine_unit_tb failed");
    $finish;
  end

endmodule
